// ===== src/aoifd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, operation codes, types and saturation helper for the option pricer.
package aoifd_pkg;

	localparam int MAX_HALF_GRID = 256;
	localparam int FRAC_BITS     = 32;
	localparam int DW            = 48;
	localparam int HG_W          = 9;
	localparam int NODE_COUNT    = 2 * MAX_HALF_GRID + 1;
	localparam int NODE_AW       = $clog2(NODE_COUNT);
	localparam int CFG_AW        = 3;

	localparam logic [CFG_AW-1:0] REG_COEF_UP      = 3'd0;
	localparam logic [CFG_AW-1:0] REG_COEF_DOWN    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_COEF_MID     = 3'd2;
	localparam logic [CFG_AW-1:0] REG_STRIKE       = 3'd3;
	localparam logic [CFG_AW-1:0] REG_GROWTH_RATIO = 3'd4;
	localparam logic [CFG_AW-1:0] REG_START_SCALE  = 3'd5;
	localparam logic [CFG_AW-1:0] REG_HALF_GRID    = 3'd6;

	localparam logic [DW-1:0] S_MAX  = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] S_MIN  = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] U_MAX  = {DW{1'b1}};
	localparam logic [DW-1:0] ONE_FX = DW'(1) << FRAC_BITS;

	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
	localparam logic [OP_W-1:0] OP_MUL_SCALE = 5'd2;
	localparam logic [OP_W-1:0] OP_PRICE     = 5'd3;
	localparam logic [OP_W-1:0] OP_MUL_GROW  = 5'd4;
	localparam logic [OP_W-1:0] OP_NODE      = 5'd5;
	localparam logic [OP_W-1:0] OP_LAM       = 5'd6;
	localparam logic [OP_W-1:0] OP_PIV1      = 5'd7;
	localparam logic [OP_W-1:0] OP_MUL_PUPD  = 5'd8;
	localparam logic [OP_W-1:0] OP_PUPD      = 5'd9;
	localparam logic [OP_W-1:0] OP_DIV_PIV   = 5'd10;
	localparam logic [OP_W-1:0] OP_PIV       = 5'd11;
	localparam logic [OP_W-1:0] OP_DIV_INV   = 5'd12;
	localparam logic [OP_W-1:0] OP_INV       = 5'd13;
	localparam logic [OP_W-1:0] OP_MUL_PDLAM = 5'd14;
	localparam logic [OP_W-1:0] OP_PDLAM     = 5'd15;
	localparam logic [OP_W-1:0] OP_SW1       = 5'd16;
	localparam logic [OP_W-1:0] OP_MUL_DPI   = 5'd17;
	localparam logic [OP_W-1:0] OP_MUL_SWM   = 5'd18;
	localparam logic [OP_W-1:0] OP_SW        = 5'd19;
	localparam logic [OP_W-1:0] OP_DIV_TOP   = 5'd20;
	localparam logic [OP_W-1:0] OP_TOP       = 5'd21;
	localparam logic [OP_W-1:0] OP_MUL_UV    = 5'd22;
	localparam logic [OP_W-1:0] OP_MUL_BS    = 5'd23;
	localparam logic [OP_W-1:0] OP_BS        = 5'd24;
	localparam logic [OP_W-1:0] OP_MAX       = 5'd25;
	localparam logic [OP_W-1:0] OP_OUT       = 5'd26;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [NODE_AW-1:0] addr;
		logic [NODE_AW-1:0] addr_b;
	} cmd_t;

	typedef struct packed {
		logic               mul_done;
		logic               div_done;
		logic [NODE_AW-1:0] top;
	} sts_t;

	typedef struct packed {
		logic [DW-1:0] val;
		logic          ovf;
	} sat_t;

	function automatic sat_t sat_sum(input logic [DW:0] x);
		sat_t r;
		r.ovf = x[DW] ^ x[DW-1];
		r.val = r.ovf ? (x[DW] ? S_MIN : S_MAX) : x[DW-1:0];
		return r;
	endfunction

endpackage

// ===== src/aoifd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the spot price input and the option value result.
interface aoifd_spot_if;
	logic          valid;
	logic          ready;
	logic [47:0]   spot_price;
	modport source (output valid, output spot_price, input ready);
	modport sink (input valid, input spot_price, output ready);
endinterface

interface aoifd_result_if;
	logic          valid;
	logic          ready;
	logic [47:0]   option_value;
	logic          arith_error;
	modport source (output valid, output option_value, output arith_error, input ready);
	modport sink (input valid, input option_value, input arith_error, output ready);
endinterface

// ===== src/american_option_implicit_fd_pricer.sv =====
`timescale 1ns / 1ps
// Top level of the American call pricer on an implicit finite-difference log-price grid.
//
// The spot channel takes one spot price per transfer; the result channel returns one
// option value and an arithmetic error flag per spot price. Both are valid/ready
// channels. Configuration registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle; index 7 is ignored.
//
// One item is priced at a time. With N the clamped half grid and S the number of
// backward steps (N rounded up to even), an item runs S backward steps after the grid
// build and the pivot setup. Each backward step runs a forward sweep and a back
// substitution of two multiplies per node on one shared multiplier, plus a maximum
// pass per node and a division at the top node. The pivot setup runs two divisions
// per node on a bit-serial divider.
//
// Reset clears the controller and loads the register defaults; the node stores are
// not cleared. The result sits in an output register, so a new spot price is taken
// while the previous result waits; if the receiver still stalls when the next result
// is ready, the block holds in its final state until the transfer completes.
module american_option_implicit_fd_pricer (
	input  logic                        clk,
	input  logic                        arst_n,
	aoifd_spot_if.sink                  spot_ch,
	aoifd_result_if.source              result_ch,
	input  logic                        cfg_we,
	input  logic [aoifd_pkg::CFG_AW-1:0] cfg_index,
	input  logic [aoifd_pkg::DW-1:0]     cfg_data
);
	import aoifd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	aoifd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.spot_valid (spot_ch.valid),
		.spot_ready (spot_ch.ready),
		.res_valid  (result_ch.valid),
		.res_ready  (result_ch.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	aoifd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.spot_price   (spot_ch.spot_price),
		.option_value (result_ch.option_value),
		.arith_error  (result_ch.arith_error)
	);
endmodule

// ===== src/aoifd_mul.sv =====
`timescale 1ns / 1ps
// Multi-cycle rounding fixed-point multiplier with saturation, signed or unsigned.
module aoifd_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    sgn,
	input  logic [aoifd_pkg::DW-1:0] a,
	input  logic [aoifd_pkg::DW-1:0] b,
	output logic [aoifd_pkg::DW-1:0] res,
	output logic                    ovf,
	output logic                    done
);
	import aoifd_pkg::*;

	localparam int HALF = DW / 2;
	localparam int RW   = 2 * DW - FRAC_BITS;
	localparam logic [2*DW-1:0] RND = (2*DW)'(1) << (FRAC_BITS - 1);

	logic [DW-1:0]      ma, mb, cap;
	logic               neg;
	logic [DW-1:0]      ma_q, mb_q, cap_q;
	logic               neg_q;
	logic [2*DW-1:0]    acc_q;
	logic [DW+HALF-1:0] pp_lo, pp_hi;
	logic [2*DW-1:0]    rnd;
	logic [RW-1:0]      rq;
	logic [DW-1:0]      mag;
	logic               busy_q, done_q, ovf_q;
	logic [1:0]         ph_q;
	logic [DW-1:0]      res_q;

	always_comb begin
		ma  = (sgn && a[DW-1]) ? -a : a;
		mb  = (sgn && b[DW-1]) ? -b : b;
		neg = sgn && (a[DW-1] ^ b[DW-1]);
		cap = !sgn ? U_MAX : (neg ? S_MIN : S_MAX);
	end

	assign pp_lo = ma_q * mb_q[HALF-1:0];
	assign pp_hi = ma_q * mb_q[DW-1:HALF];
	assign rnd   = acc_q + RND;
	assign rq    = rnd[2*DW-1:FRAC_BITS];
	assign mag   = (rq > RW'(cap_q)) ? cap_q : rq[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 2'd0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= ma;
			mb_q  <= mb;
			cap_q <= cap;
			neg_q <= neg;
		end else if (busy_q) begin
			case (ph_q)
				2'd0: acc_q <= (2*DW)'(pp_lo);
				2'd1: acc_q <= acc_q + ((2*DW)'(pp_hi) << HALF);
				default: begin
					res_q <= neg_q ? -mag : mag;
					ovf_q <= rq > RW'(cap_q);
				end
			endcase
		end
	end

	assign res  = res_q;
	assign ovf  = ovf_q;
	assign done = done_q;
endmodule

// ===== src/aoifd_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring fixed-point divider with rounding, saturation and zero-divisor flag.
module aoifd_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [aoifd_pkg::DW-1:0] a,
	input  logic [aoifd_pkg::DW-1:0] b,
	output logic [aoifd_pkg::DW-1:0] res,
	output logic                    ovf,
	output logic                    done
);
	import aoifd_pkg::*;

	localparam int ITER = DW + FRAC_BITS;
	localparam int CW   = $clog2(ITER);

	logic [DW-1:0] ma, mb;
	logic [DW-1:0] mb_q, cap_q, dd_q, r_q, q_q, res_q;
	logic          neg_q, sat_q, ovf_q, busy_q, fin_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rs, qn, qr;
	logic          ge, up;
	logic [DW-1:0] rn, mag;

	assign ma = a[DW-1] ? -a : a;
	assign mb = b[DW-1] ? -b : b;

	always_comb begin
		rs  = {r_q, dd_q[DW-1]};
		ge  = rs >= {1'b0, mb_q};
		rn  = ge ? DW'(rs - {1'b0, mb_q}) : rs[DW-1:0];
		qn  = {q_q, ge};
		up  = {r_q, 1'b0} >= {1'b0, mb_q};
		qr  = {1'b0, q_q} + (DW+1)'(up);
		mag = (sat_q || qr > {1'b0, cap_q}) ? cap_q : qr[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (b == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(ITER - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mb_q  <= mb;
			dd_q  <= ma;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
			neg_q <= a[DW-1] ^ b[DW-1];
			cap_q <= (a[DW-1] ^ b[DW-1]) ? S_MIN : S_MAX;
			if (b == '0) begin
				res_q <= '0;
				ovf_q <= 1'b1;
			end
		end else if (busy_q) begin
			dd_q <= dd_q << 1;
			r_q  <= rn;
			if (!sat_q) begin
				if (qn > {1'b0, cap_q}) begin
					sat_q <= 1'b1;
				end else begin
					q_q <= qn[DW-1:0];
				end
			end
		end else if (fin_q) begin
			res_q <= neg_q ? -mag : mag;
			ovf_q <= sat_q || qr > {1'b0, cap_q};
		end
	end

	assign res  = res_q;
	assign ovf  = ovf_q;
	assign done = done_q;
endmodule

// ===== src/aoifd_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, node stores, arithmetic units and result register.
module aoifd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aoifd_pkg::cmd_t             cmd,
	output aoifd_pkg::sts_t             sts,
	input  logic                        cfg_we,
	input  logic [aoifd_pkg::CFG_AW-1:0] cfg_index,
	input  logic [aoifd_pkg::DW-1:0]     cfg_data,
	input  logic [aoifd_pkg::DW-1:0]     spot_price,
	output logic [aoifd_pkg::DW-1:0]     option_value,
	output logic                        arith_error
);
	import aoifd_pkg::*;

	logic [DW-1:0]   coef_up_q, coef_down_q, coef_mid_q, strike_q, growth_q, scale_q;
	logic [HG_W-1:0] half_grid_q, n_cl;

	logic [DW-1:0] payoff_mem [NODE_COUNT];
	logic [DW-1:0] pivot_mem  [NODE_COUNT];
	logic [DW-1:0] pinv_mem   [NODE_COUNT];
	logic [DW-1:0] sweep_mem  [NODE_COUNT];
	logic [DW-1:0] value_mem  [NODE_COUNT];

	logic [DW-1:0] pay_rd_q, piv_rd_q, pinv_rd_q, sw_rd_q, val_rd_q;
	logic [DW-1:0] spot_q, price_q, p0_q, p1_q, pupd_q, pdlam_q, lam_q;
	logic [DW-1:0] piv_prev_q, sw_prev_q, vnext_q, opt_q;
	logic          fault_q, err_q;

	logic          mul_start, mul_sgn, mul_ovf, mul_done;
	logic [DW-1:0] mul_a, mul_b, mul_res;
	logic          div_start, div_ovf, div_done;
	logic [DW-1:0] div_a, div_b, div_res;

	sat_t          s_piv1, s_piv, s_sw1, s_sw, top_den, bs_diff;
	logic [DW+1:0] lam_x;
	logic [DW-1:0] lam_v, pay_d, val_wd, max_v;
	logic          lam_ovf, pay_ovf, op_ovf, val_we;

	always_comb begin
		if (half_grid_q < HG_W'(2)) n_cl = HG_W'(2);
		else if (half_grid_q > HG_W'(MAX_HALF_GRID)) n_cl = HG_W'(MAX_HALF_GRID);
		else n_cl = half_grid_q;
	end

	assign sts.top      = NODE_AW'(n_cl) << 1;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_up_q   <= '0;
			coef_down_q <= '0;
			coef_mid_q  <= ONE_FX;
			strike_q    <= '0;
			growth_q    <= ONE_FX;
			scale_q     <= ONE_FX;
			half_grid_q <= HG_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_UP:      coef_up_q   <= cfg_data;
				REG_COEF_DOWN:    coef_down_q <= cfg_data;
				REG_COEF_MID:     coef_mid_q  <= cfg_data;
				REG_STRIKE:       strike_q    <= cfg_data;
				REG_GROWTH_RATIO: growth_q    <= cfg_data;
				REG_START_SCALE:  scale_q     <= cfg_data;
				REG_HALF_GRID:    half_grid_q <= cfg_data[HG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		s_piv1  = sat_sum({coef_mid_q[DW-1], coef_mid_q} + {coef_down_q[DW-1], coef_down_q});
		s_piv   = sat_sum({coef_mid_q[DW-1], coef_mid_q} - {div_res[DW-1], div_res});
		s_sw1   = sat_sum({val_rd_q[DW-1], val_rd_q} + {pdlam_q[DW-1], pdlam_q});
		s_sw    = sat_sum({val_rd_q[DW-1], val_rd_q} - {mul_res[DW-1], mul_res});
		top_den = sat_sum({coef_up_q[DW-1], coef_up_q} + {piv_prev_q[DW-1], piv_prev_q});
		bs_diff = sat_sum({sw_rd_q[DW-1], sw_rd_q} - {mul_res[DW-1], mul_res});
		lam_x   = {2'b00, p0_q} - {2'b00, p1_q};
		lam_ovf = !((lam_x[DW+1:DW-1] == 3'b000) || (lam_x[DW+1:DW-1] == 3'b111));
		lam_v   = lam_ovf ? (lam_x[DW+1] ? S_MIN : S_MAX) : lam_x[DW-1:0];
		pay_ovf = 1'b0;
		pay_d   = '0;
		if (mul_res > strike_q) begin
			pay_d = mul_res - strike_q;
			if (pay_d[DW-1]) begin
				pay_ovf = 1'b1;
				pay_d   = S_MAX;
			end
		end
		max_v = ($signed(pay_rd_q) > $signed(val_rd_q)) ? pay_rd_q : val_rd_q;
	end

	always_comb begin
		mul_start = 1'b1;
		mul_sgn   = 1'b1;
		mul_a     = coef_up_q;
		mul_b     = coef_down_q;
		case (cmd.op)
			OP_MUL_SCALE: begin mul_sgn = 1'b0; mul_a = spot_q;  mul_b = scale_q; end
			OP_MUL_GROW:  begin mul_sgn = 1'b0; mul_a = price_q; mul_b = growth_q; end
			OP_MUL_PUPD:  ;
			OP_MUL_PDLAM: begin mul_a = coef_down_q; mul_b = lam_q; end
			OP_MUL_DPI:   begin mul_a = coef_down_q; mul_b = pinv_rd_q; end
			OP_MUL_SWM:   begin mul_a = sw_prev_q; mul_b = mul_res; end
			OP_MUL_UV:    begin mul_a = coef_up_q; mul_b = vnext_q; end
			OP_MUL_BS:    begin mul_a = bs_diff.val; mul_b = pinv_rd_q; end
			default:      mul_start = 1'b0;
		endcase
	end

	always_comb begin
		div_start = 1'b1;
		div_a     = pupd_q;
		div_b     = piv_prev_q;
		case (cmd.op)
			OP_DIV_PIV: ;
			OP_DIV_INV: begin div_a = ONE_FX; div_b = piv_rd_q; end
			OP_DIV_TOP: begin div_a = sw_prev_q; div_b = top_den.val; end
			default:    div_start = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_NODE:    op_ovf = pay_ovf;
			OP_LAM:     op_ovf = lam_ovf;
			OP_PIV1:    op_ovf = s_piv1.ovf;
			OP_PIV:     op_ovf = s_piv.ovf;
			OP_SW1:     op_ovf = s_sw1.ovf;
			OP_SW:      op_ovf = s_sw.ovf;
			OP_DIV_TOP: op_ovf = top_den.ovf;
			OP_MUL_BS:  op_ovf = bs_diff.ovf;
			default:    op_ovf = 1'b0;
		endcase
		val_we = 1'b1;
		case (cmd.op)
			OP_NODE: val_wd = pay_d;
			OP_TOP:  val_wd = div_res;
			OP_BS:   val_wd = mul_res;
			OP_MAX:  val_wd = max_v;
			default: begin
				val_we = 1'b0;
				val_wd = max_v;
			end
		endcase
	end

	aoifd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.sgn    (mul_sgn),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.ovf    (mul_ovf),
		.done   (mul_done)
	);

	aoifd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.res    (div_res),
		.ovf    (div_ovf),
		.done   (div_done)
	);

	always_ff @(posedge clk) begin
		pay_rd_q  <= payoff_mem[cmd.addr];
		piv_rd_q  <= pivot_mem[cmd.addr];
		sw_rd_q   <= sweep_mem[cmd.addr];
		val_rd_q  <= value_mem[cmd.addr];
		pinv_rd_q <= pinv_mem[cmd.addr_b];
		if (cmd.op == OP_NODE) payoff_mem[cmd.addr] <= pay_d;
		if (val_we) value_mem[cmd.addr] <= val_wd;
		if (cmd.op == OP_PIV1) pivot_mem[cmd.addr] <= s_piv1.val;
		if (cmd.op == OP_PIV) pivot_mem[cmd.addr] <= s_piv.val;
		if (cmd.op == OP_INV) pinv_mem[cmd.addr] <= div_res;
		if (cmd.op == OP_SW1) sweep_mem[cmd.addr] <= s_sw1.val;
		if (cmd.op == OP_SW) sweep_mem[cmd.addr] <= s_sw.val;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			fault_q <= 1'b0;
		end else if (op_ovf || (mul_done && mul_ovf) || (div_done && div_ovf)) begin
			fault_q <= 1'b1;
		end
		case (cmd.op)
			OP_LOAD:  spot_q <= spot_price;
			OP_PRICE: price_q <= mul_res;
			OP_NODE: begin
				price_q <= mul_res;
				if (cmd.addr == NODE_AW'(0)) p0_q <= mul_res;
				if (cmd.addr == NODE_AW'(1)) p1_q <= mul_res;
			end
			OP_LAM:   lam_q <= lam_v;
			OP_PIV1:  piv_prev_q <= s_piv1.val;
			OP_PUPD:  pupd_q <= mul_res;
			OP_PIV:   piv_prev_q <= s_piv.val;
			OP_PDLAM: pdlam_q <= mul_res;
			OP_SW1:   sw_prev_q <= s_sw1.val;
			OP_SW:    sw_prev_q <= s_sw.val;
			OP_TOP:   vnext_q <= div_res;
			OP_BS:    vnext_q <= mul_res;
			OP_OUT: begin
				opt_q <= val_rd_q;
				err_q <= fault_q;
			end
			default: ;
		endcase
	end

	assign option_value = opt_q;
	assign arith_error  = err_q;
endmodule

// ===== src/aoifd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences grid build, pivots and the backward steps.
module aoifd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            spot_valid,
	output logic            spot_ready,
	output logic            res_valid,
	input  logic            res_ready,
	output aoifd_pkg::cmd_t cmd,
	input  aoifd_pkg::sts_t sts
);
	import aoifd_pkg::*;

	localparam logic [5:0] S_IDLE    = 6'd0;
	localparam logic [5:0] S_SCALE   = 6'd1;
	localparam logic [5:0] S_SCALE_W = 6'd2;
	localparam logic [5:0] S_GROW    = 6'd3;
	localparam logic [5:0] S_GROW_W  = 6'd4;
	localparam logic [5:0] S_LAM     = 6'd5;
	localparam logic [5:0] S_PIV1    = 6'd6;
	localparam logic [5:0] S_PUPD    = 6'd7;
	localparam logic [5:0] S_PUPD_W  = 6'd8;
	localparam logic [5:0] S_PDIV    = 6'd9;
	localparam logic [5:0] S_PDIV_W  = 6'd10;
	localparam logic [5:0] S_IRD     = 6'd11;
	localparam logic [5:0] S_IDIV    = 6'd12;
	localparam logic [5:0] S_IDIV_W  = 6'd13;
	localparam logic [5:0] S_PDL     = 6'd14;
	localparam logic [5:0] S_PDL_W   = 6'd15;
	localparam logic [5:0] S_S1RD    = 6'd16;
	localparam logic [5:0] S_SW1     = 6'd17;
	localparam logic [5:0] S_SRD     = 6'd18;
	localparam logic [5:0] S_SDPI    = 6'd19;
	localparam logic [5:0] S_SDPI_W  = 6'd20;
	localparam logic [5:0] S_SSWM    = 6'd21;
	localparam logic [5:0] S_SSWM_W  = 6'd22;
	localparam logic [5:0] S_TOP     = 6'd23;
	localparam logic [5:0] S_TOP_W   = 6'd24;
	localparam logic [5:0] S_TOP2    = 6'd25;
	localparam logic [5:0] S_BRD     = 6'd26;
	localparam logic [5:0] S_BUV     = 6'd27;
	localparam logic [5:0] S_BUV_W   = 6'd28;
	localparam logic [5:0] S_BBS     = 6'd29;
	localparam logic [5:0] S_BBS_W   = 6'd30;
	localparam logic [5:0] S_MRD     = 6'd31;
	localparam logic [5:0] S_MAX     = 6'd32;
	localparam logic [5:0] S_ORD     = 6'd33;
	localparam logic [5:0] S_OUT     = 6'd34;

	localparam logic [NODE_AW-1:0] J_ONE = NODE_AW'(1);
	localparam logic [NODE_AW-1:0] J_TWO = NODE_AW'(2);

	logic [5:0]         st_q, st_d;
	logic [NODE_AW-1:0] j_q, j_d, n_node, stp, last_step;
	logic [NODE_AW-2:0] s_q, s_d;
	logic               out_valid_q, out_set, fwd;

	assign n_node    = {1'b0, sts.top[NODE_AW-1:1]};
	assign stp       = (n_node + J_ONE) & ~J_ONE;
	assign last_step = stp - J_ONE;
	assign fwd       = (st_q inside {S_SRD, S_SDPI, S_SDPI_W, S_SSWM, S_SSWM_W});

	always_comb begin
		st_d       = st_q;
		j_d        = j_q;
		s_d        = s_q;
		out_set    = 1'b0;
		cmd.op     = OP_NONE;
		cmd.addr   = j_q;
		cmd.addr_b = fwd ? j_q - J_ONE : j_q;
		case (st_q)
			S_IDLE: begin
				if (spot_valid) begin
					cmd.op = OP_LOAD;
					st_d   = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.op = OP_MUL_SCALE;
				st_d   = S_SCALE_W;
			end
			S_SCALE_W: begin
				if (sts.mul_done) begin
					cmd.op = OP_PRICE;
					j_d    = '0;
					st_d   = S_GROW;
				end
			end
			S_GROW: begin
				cmd.op = OP_MUL_GROW;
				st_d   = S_GROW_W;
			end
			S_GROW_W: begin
				if (sts.mul_done) begin
					cmd.op = OP_NODE;
					if (j_q == sts.top) begin
						st_d = S_LAM;
					end else begin
						j_d  = j_q + J_ONE;
						st_d = S_GROW;
					end
				end
			end
			S_LAM: begin
				cmd.op = OP_LAM;
				j_d    = J_ONE;
				st_d   = S_PIV1;
			end
			S_PIV1: begin
				cmd.op = OP_PIV1;
				st_d   = S_PUPD;
			end
			S_PUPD: begin
				cmd.op = OP_MUL_PUPD;
				st_d   = S_PUPD_W;
			end
			S_PUPD_W: begin
				if (sts.mul_done) begin
					cmd.op = OP_PUPD;
					j_d    = J_TWO;
					st_d   = S_PDIV;
				end
			end
			S_PDIV: begin
				cmd.op = OP_DIV_PIV;
				st_d   = S_PDIV_W;
			end
			S_PDIV_W: begin
				if (sts.div_done) begin
					cmd.op = OP_PIV;
					if (j_q == sts.top - J_ONE) begin
						j_d  = J_ONE;
						st_d = S_IRD;
					end else begin
						j_d  = j_q + J_ONE;
						st_d = S_PDIV;
					end
				end
			end
			S_IRD: st_d = S_IDIV;
			S_IDIV: begin
				cmd.op = OP_DIV_INV;
				st_d   = S_IDIV_W;
			end
			S_IDIV_W: begin
				if (sts.div_done) begin
					cmd.op = OP_INV;
					if (j_q == sts.top - J_TWO) begin
						st_d = S_PDL;
					end else begin
						j_d  = j_q + J_ONE;
						st_d = S_IRD;
					end
				end
			end
			S_PDL: begin
				cmd.op = OP_MUL_PDLAM;
				st_d   = S_PDL_W;
			end
			S_PDL_W: begin
				if (sts.mul_done) begin
					cmd.op = OP_PDLAM;
					j_d    = J_ONE;
					s_d    = '0;
					st_d   = S_S1RD;
				end
			end
			S_S1RD: st_d = S_SW1;
			S_SW1: begin
				cmd.op = OP_SW1;
				j_d    = J_TWO;
				st_d   = S_SRD;
			end
			S_SRD: st_d = S_SDPI;
			S_SDPI: begin
				cmd.op = OP_MUL_DPI;
				st_d   = S_SDPI_W;
			end
			S_SDPI_W: begin
				if (sts.mul_done) st_d = S_SSWM;
			end
			S_SSWM: begin
				cmd.op = OP_MUL_SWM;
				st_d   = S_SSWM_W;
			end
			S_SSWM_W: begin
				if (sts.mul_done) begin
					cmd.op = OP_SW;
					if (j_q == sts.top - J_ONE) begin
						j_d  = sts.top;
						st_d = S_TOP;
					end else begin
						j_d  = j_q + J_ONE;
						st_d = S_SRD;
					end
				end
			end
			S_TOP: begin
				cmd.op = OP_DIV_TOP;
				st_d   = S_TOP_W;
			end
			S_TOP_W: begin
				if (sts.div_done) begin
					cmd.op = OP_TOP;
					j_d    = sts.top - J_ONE;
					st_d   = S_TOP2;
				end
			end
			S_TOP2: begin
				cmd.op = OP_TOP;
				j_d    = sts.top - J_TWO;
				st_d   = S_BRD;
			end
			S_BRD: st_d = S_BUV;
			S_BUV: begin
				cmd.op = OP_MUL_UV;
				st_d   = S_BUV_W;
			end
			S_BUV_W: begin
				if (sts.mul_done) st_d = S_BBS;
			end
			S_BBS: begin
				cmd.op = OP_MUL_BS;
				st_d   = S_BBS_W;
			end
			S_BBS_W: begin
				if (sts.mul_done) begin
					cmd.op = OP_BS;
					if (j_q == J_ONE) begin
						j_d  = '0;
						st_d = S_MRD;
					end else begin
						j_d  = j_q - J_ONE;
						st_d = S_BRD;
					end
				end
			end
			S_MRD: st_d = S_MAX;
			S_MAX: begin
				cmd.op = OP_MAX;
				if (j_q == sts.top) begin
					if (NODE_AW'(s_q) == last_step) begin
						j_d  = n_node;
						st_d = S_ORD;
					end else begin
						s_d  = s_q + 1'b1;
						j_d  = J_ONE;
						st_d = S_S1RD;
					end
				end else begin
					j_d  = j_q + J_ONE;
					st_d = S_MRD;
				end
			end
			S_ORD: st_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || res_ready) begin
					cmd.op  = OP_OUT;
					out_set = 1'b1;
					st_d    = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			j_q         <= '0;
			s_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			j_q  <= j_d;
			s_q  <= s_d;
			if (out_set) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	assign spot_ready = (st_q == S_IDLE);
	assign res_valid  = out_valid_q;

	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q) == S_OUT)
		else $error("result raised outside the output state");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.mul_done && sts.div_done))
		else $error("multiplier and divider finished together");

	a_index_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE && st_q != S_SCALE && st_q != S_SCALE_W) |-> j_q <= sts.top)
		else $error("node index beyond the top node");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(spot_valid && spot_ready) |=> st_q == S_SCALE)
		else $error("accepted spot price did not start pricing");
endmodule

// ===== dv/american_option_implicit_fd_pricer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench that prices spot prices under several grid settings and compares results.
module american_option_implicit_fd_pricer_tb;
	import aoifd_pkg::*;

	typedef struct {
		logic [47:0] value;
		logic        err;
	} quote_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_AW-1:0]   cfg_index = '0;
	logic [DW-1:0]       cfg_data = '0;

	aoifd_spot_if   spot_ch ();
	aoifd_result_if result_ch ();

	american_option_implicit_fd_pricer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.spot_ch   (spot_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	localparam longint SMAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint SMIN = -SMAX - 1;
	localparam longint ONE  = 64'sh1_0000_0000;

	longint      m_up, m_down, m_mid;
	logic [47:0] m_strike, m_growth, m_scale;
	logic [8:0]  m_half;

	longint payoff_node [0:NODE_COUNT-1];
	longint pivot_node [0:NODE_COUNT-1];
	longint pivinv_node [0:NODE_COUNT-1];
	longint sweep_node [0:NODE_COUNT-1];
	longint value_node [0:NODE_COUNT-1];
	bit     calc_fault;

	logic [47:0] spot_pending [$];
	quote_t      quote_q [$];
	int          mismatch_count = 0;
	bit          no_idle = 1'b0;
	int          spot_gap, result_stall;
	quote_t      want;

	function automatic longint clamp48(longint x);
		if (x > SMAX) begin
			calc_fault = 1'b1;
			return SMAX;
		end
		if (x < SMIN) begin
			calc_fault = 1'b1;
			return SMIN;
		end
		return x;
	endfunction

	function automatic logic [63:0] mul_mag(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (p > {64'd0, cap}) begin
			calc_fault = 1'b1;
			return cap;
		end
		return p[63:0];
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		bit          neg;
		logic [63:0] ma, mb, m;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		m = mul_mag(ma, mb, neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint fx_div(longint a, longint b);
		bit           neg;
		logic [127:0] num, den, q, r, cap;
		if (b == 0) begin
			calc_fault = 1'b1;
			return 0;
		end
		neg = (a < 0) != (b < 0);
		num = {64'd0, 64'((a < 0) ? -a : a)} << FRAC_BITS;
		den = {64'd0, 64'((b < 0) ? -b : b)};
		cap = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
		q = num / den;
		r = num % den;
		if (q > cap) begin
			calc_fault = 1'b1;
			q = cap;
		end else begin
			if (2 * r >= den)
				q = q + 1;
			if (q > cap) begin
				calc_fault = 1'b1;
				q = cap;
			end
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic quote_t price_call(logic [47:0] spot);
		int          n, top, steps;
		logic [63:0] price, p0, p1, d;
		longint      lam, pupd, pdlam, t;
		quote_t      res;
		calc_fault = 1'b0;
		n = m_half;
		if (n < 2) n = 2;
		if (n > MAX_HALF_GRID) n = MAX_HALF_GRID;
		top = 2 * n;
		p0 = 0;
		p1 = 0;
		price = mul_mag(spot, m_scale, 64'hFFFF_FFFF_FFFF);
		for (int j = 0; j <= top; j++) begin
			price = mul_mag(price, m_growth, 64'hFFFF_FFFF_FFFF);
			if (j == 0) p0 = price;
			if (j == 1) p1 = price;
			if (price > m_strike) begin
				d = price - m_strike;
				if (d > 64'h7FFF_FFFF_FFFF) begin
					calc_fault = 1'b1;
					d = 64'h7FFF_FFFF_FFFF;
				end
				payoff_node[j] = d;
			end else begin
				payoff_node[j] = 0;
			end
			value_node[j] = payoff_node[j];
		end
		lam = clamp48(longint'(p0) - longint'(p1));
		pivot_node[1] = clamp48(m_mid + m_down);
		pupd = fx_mul(m_up, m_down);
		for (int j = 2; j < top; j++)
			pivot_node[j] = clamp48(m_mid - fx_div(pupd, pivot_node[j-1]));
		for (int j = 1; j <= top - 2; j++)
			pivinv_node[j] = fx_div(ONE, pivot_node[j]);
		pdlam = fx_mul(m_down, lam);
		steps = (n + 1) & ~1;
		for (int s = 0; s < steps; s++) begin
			sweep_node[1] = clamp48(value_node[1] + pdlam);
			for (int j = 2; j < top; j++)
				sweep_node[j] = clamp48(value_node[j] -
					fx_mul(sweep_node[j-1], fx_mul(m_down, pivinv_node[j-1])));
			t = fx_div(sweep_node[top-1], clamp48(m_up + pivot_node[top-1]));
			value_node[top] = t;
			value_node[top-1] = t;
			for (int j = top - 2; j >= 1; j--)
				value_node[j] = fx_mul(clamp48(sweep_node[j] - fx_mul(m_up, value_node[j+1])),
					pivinv_node[j]);
			for (int j = 0; j <= top; j++)
				if (payoff_node[j] > value_node[j]) value_node[j] = payoff_node[j];
		end
		res.value = value_node[n][47:0];
		res.err = calc_fault;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 18) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spot_ch.valid <= 1'b0;
			spot_ch.spot_price <= '0;
			spot_gap <= 0;
		end else begin
			if (spot_ch.valid && spot_ch.ready)
				quote_q.push_back(price_call(spot_ch.spot_price));
			if (!spot_ch.valid || spot_ch.ready) begin
				if (spot_gap > 0) begin
					spot_gap <= spot_gap - 1;
					spot_ch.valid <= 1'b0;
				end else if (spot_pending.size() > 0) begin
					spot_ch.valid <= 1'b1;
					spot_ch.spot_price <= spot_pending.pop_front();
					spot_gap <= pick_gap();
				end else begin
					spot_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			result_stall <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (quote_q.size() == 0) begin
					$error("unexpected result option_value=%h", result_ch.option_value);
					mismatch_count++;
				end else begin
					want = quote_q.pop_front();
					if (result_ch.option_value !== want.value) begin
						$error("option_value expected %h actual %h", want.value,
							result_ch.option_value);
						mismatch_count++;
					end
					if (result_ch.arith_error !== want.err) begin
						$error("arith_error expected %b actual %b", want.err,
							result_ch.arith_error);
						mismatch_count++;
					end
				end
			end
			if (result_stall > 0) begin
				result_stall <= result_stall - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (result_ch.valid && result_ch.ready) result_stall <= pick_gap();
			end
		end
	end

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [47:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_COEF_UP:      m_up = $signed(d);
			REG_COEF_DOWN:    m_down = $signed(d);
			REG_COEF_MID:     m_mid = $signed(d);
			REG_STRIKE:       m_strike = d;
			REG_GROWTH_RATIO: m_growth = d;
			REG_START_SCALE:  m_scale = d;
			REG_HALF_GRID:    m_half = d[8:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (spot_pending.size() > 0 || spot_ch.valid || quote_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_grid(longint up, longint down, longint mid, logic [47:0] k,
			logic [47:0] g, logic [47:0] sc, logic [8:0] hg);
		wait_idle();
		write_reg(REG_COEF_UP, up[47:0]);
		write_reg(REG_COEF_DOWN, down[47:0]);
		write_reg(REG_COEF_MID, mid[47:0]);
		write_reg(REG_STRIKE, k);
		write_reg(REG_GROWTH_RATIO, g);
		write_reg(REG_START_SCALE, sc);
		write_reg(REG_HALF_GRID, {39'd0, hg});
		@(posedge clk);
		cfg_we <= 1'b0;
		no_idle = ($urandom_range(0, 3) == 0);
	endtask

	task automatic market_grid(logic [8:0] hg);
		longint a, b;
		a = $urandom_range(0, 32'h8000_0000);
		b = $urandom_range(0, 32'h8000_0000);
		set_grid(-b, -a, ONE + a + b + $urandom_range(0, 32'h0100_0000),
			{16'($urandom_range(60, 140)), 32'($urandom)},
			48'(ONE + $urandom_range(0, 32'h1000_0000)),
			48'(ONE - $urandom_range(0, 32'h8000_0000)), hg);
	endtask

	function automatic logic [47:0] rand_spot();
		if ($urandom_range(0, 4) == 0) return {16'($urandom), 32'($urandom)};
		return {16'($urandom_range(50, 150)), 32'($urandom)};
	endfunction

	initial begin
		m_up = 0;
		m_down = 0;
		m_mid = ONE;
		m_strike = 0;
		m_growth = ONE;
		m_scale = ONE;
		m_half = 2;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		spot_pending.push_back(48'd0);
		spot_pending.push_back(U_MAX);
		spot_pending.push_back(48'd1);
		spot_pending.push_back(48'h64_0000_0000);

		market_grid(9'd2);
		repeat (3) spot_pending.push_back(rand_spot());
		market_grid(9'd3);
		repeat (3) spot_pending.push_back(rand_spot());

		set_grid(0, 0, 0, 48'h64_0000_0000, 48'(ONE), 48'(ONE), 9'd0);
		spot_pending.push_back(48'h64_0000_0000);
		spot_pending.push_back(48'hC8_0000_0000);

		set_grid(SMIN, SMAX, SMAX, U_MAX, U_MAX, U_MAX, 9'd1);
		spot_pending.push_back(48'd0);
		spot_pending.push_back(U_MAX);

		set_grid(SMAX, SMIN, SMIN, 48'd0, 48'd0, 48'd0, 9'd4);
		spot_pending.push_back(U_MAX);
		set_grid(-ONE, -ONE, 3 * ONE, 48'd0, 48'(ONE), 48'(ONE), 9'd5);
		spot_pending.push_back(48'h64_0000_0000);

		market_grid(9'd64);
		spot_pending.push_back(rand_spot());
		market_grid(9'd16);
		spot_pending.push_back(rand_spot());

		for (int p = 0; p < 12; p++) begin
			if ($urandom_range(0, 3) == 0)
				set_grid($signed(48'({$urandom, $urandom})), $signed(48'({$urandom, $urandom})),
					$signed(48'({$urandom, $urandom})), {16'($urandom), 32'($urandom)},
					{16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
					9'($urandom_range(0, 7)));
			else
				market_grid(9'($urandom_range(2, 8)));
			repeat (8) spot_pending.push_back(rand_spot());
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && quote_q.size() == 0)
			$display("american_option_implicit_fd_pricer_tb passed");
		else
			$display("american_option_implicit_fd_pricer_tb failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("american_option_implicit_fd_pricer_tb failed");
		$finish;
	end

endmodule
